// File: rtl/sme_pkg.sv
package sme_pkg;

    // Program memory size; next_pc wraps at this power of two.
    localparam int PROGRAM_SIZE = 4096;

    // Instruction codes.
    typedef enum logic [3:0] {
        OP_HALT  = 4'd0,
        OP_PUSH  = 4'd1,
        OP_POP   = 4'd2,
        OP_ADD   = 4'd3,
        OP_SUB   = 4'd4,
        OP_MUL   = 4'd5,
        OP_DIV   = 4'd6,
        OP_JMP   = 4'd7,
        OP_JE    = 4'd8,
        OP_JL    = 4'd9,
        OP_JG    = 4'd10,
        OP_PUSHV = 4'd11,
        OP_POPV  = 4'd12,
        OP_OUT   = 4'd13,
        OP_NOP   = 4'd14,
        OP_UNDEF = 4'd15
    } op_t;

    // Status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_OVER    = 3'd2;
    localparam logic [2:0] ST_UNDER   = 3'd3;
    localparam logic [2:0] ST_DIVZ    = 3'd4;
    localparam logic [2:0] ST_UNKNOWN = 3'd5;

endpackage

// File: rtl/stack_machine_executor.sv
// Executes one stack-machine instruction per accepted item and returns one
// result item for it. The operand stack is a RAM with one registered read
// port, so the two operands are read one after the other; mul goes through a
// shared 16-bit partial product unit that forms three partial products, and
// div goes through a radix-2 restoring divider that produces one quotient bit
// per cycle. The block accepts no new item until the result of the previous
// one is taken, and the next item is accepted in the cycle after that at the
// earliest. After reset a clearing pass zeroes the variable store before the
// first item is accepted.
module stack_machine_executor #(
    parameter int STACK_DEPTH  = 64,
    parameter int VAR_SLOTS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  op,
    input  logic signed [31:0] imm_value,
    input  logic [11:0] jump_target,
    input  logic [3:0]  var_index,
    output logic        out_valid_o,
    input  logic        out_stall,
    output logic [11:0] next_pc,
    output logic [2:0]  status,
    output logic        out_valid,
    output logic signed [31:0] out_value,
    output logic [6:0]  stack_depth
);

    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int VAW = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;
    localparam int PCW = $clog2(sme_pkg::PROGRAM_SIZE);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RDB   = 4'd2;
    localparam logic [3:0] S_RDA   = 4'd3;
    localparam logic [3:0] S_EXEC  = 4'd4;
    localparam logic [3:0] S_ITER  = 4'd5;
    localparam logic [3:0] S_WB    = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_RDV   = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [PCW-1:0]   pc_reg;
    logic [SPW-1:0]   sp_reg;
    logic [2:0]       stop_reg;
    logic [VAW-1:0]   clr_reg;

    logic [3:0]       op_reg;
    logic [31:0]      imm_reg;
    logic [11:0]      tgt_reg;
    logic [VAW-1:0]   slot_reg;
    logic [31:0]      a_reg, b_reg;
    logic [31:0]      acc_reg;
    logic [31:0]      rem_reg;
    logic [5:0]       cnt_reg;
    logic             neg_reg;

    logic             res_vld_reg;
    logic [11:0]      r_pc_reg;
    logic [2:0]       r_st_reg;
    logic             r_ov_reg;
    logic [31:0]      r_val_reg;
    logic [6:0]       r_sd_reg;

    // Stack RAM ports.
    logic             s_we;
    logic [SAW-1:0]   s_waddr, s_raddr;
    logic [31:0]      s_wdata, s_rdata;

    // Variable RAM ports.
    logic             v_we;
    logic [VAW-1:0]   v_waddr, v_raddr;
    logic [31:0]      v_wdata, v_rdata;

    // Slot index for each value of var_index, wrapped to the store size.
    logic [VAW-1:0]   slot_map [16];

    sme_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    sme_ram #(.WIDTH(32), .DEPTH(VAR_SLOTS)) u_vars (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    for (genvar g = 0; g < 16; g++)
    begin : g_slot
        assign slot_map[g] = VAW'(g % VAR_SLOTS);
    end

    logic [PCW-1:0] pc_inc, jmp_nxt;
    logic [SPW-1:0] sp_m1, sp_m2;
    logic           full, has1, has2;
    logic           binop, cjmp, take;
    logic [32:0]    trial;
    logic [15:0]    mul_x, mul_y;
    logic [31:0]    mul_p;
    logic [31:0]    mres;
    logic [31:0]    ua, ub;

    assign pc_inc  = pc_reg + 1'b1;
    assign jmp_nxt = tgt_reg[PCW-1:0] + 1'b1;
    assign sp_m1   = sp_reg - 1'b1;
    assign sp_m2   = sp_reg - 2'd2;
    assign full    = (sp_reg >= SPW'(STACK_DEPTH));
    assign has1    = (sp_reg != '0);
    assign has2    = (sp_reg >= SPW'(2));
    assign binop   = (op_reg == sme_pkg::OP_ADD) || (op_reg == sme_pkg::OP_SUB) ||
                     (op_reg == sme_pkg::OP_MUL) || (op_reg == sme_pkg::OP_DIV);
    assign cjmp    = (op_reg == sme_pkg::OP_JE) || (op_reg == sme_pkg::OP_JL) ||
                     (op_reg == sme_pkg::OP_JG);
    assign ua      = a_reg[31] ? (32'd0 - a_reg) : a_reg;
    assign ub      = b_reg[31] ? (32'd0 - b_reg) : b_reg;
    assign trial   = {rem_reg, acc_reg[31]} - {1'b0, ub};
    // Shared 16x16 partial product: low halves first, then the two cross terms.
    assign mul_x   = (cnt_reg == 6'd2) ? a_reg[31:16] : a_reg[15:0];
    assign mul_y   = (cnt_reg == 6'd1) ? b_reg[31:16] : b_reg[15:0];
    assign mul_p   = 32'(mul_x) * 32'(mul_y);
    assign mres    = (cnt_reg == 6'd0) ? mul_p : (mul_p << 16);

    always_comb
    begin
        unique case (op_reg)
            sme_pkg::OP_JE: take = (a_reg == b_reg);
            sme_pkg::OP_JL: take = ($signed(a_reg) < $signed(b_reg));
            default:        take = ($signed(a_reg) > $signed(b_reg));
        endcase
    end

    assign in_stall    = (state_reg != S_IDLE) || res_vld_reg;
    assign out_valid_o = res_vld_reg;
    assign next_pc     = r_pc_reg;
    assign status      = r_st_reg;
    assign out_valid   = r_ov_reg;
    assign out_value   = r_val_reg;
    assign stack_depth = r_sd_reg;

    // RAM address and write control.
    always_comb
    begin
        s_we    = 1'b0;
        s_waddr = sp_reg[SAW-1:0];
        s_wdata = acc_reg;
        s_raddr = sp_m1[SAW-1:0];
        v_we    = 1'b0;
        v_waddr = slot_reg;
        v_wdata = s_rdata;
        v_raddr = slot_reg;
        if (state_reg == S_CLEAR)
        begin
            v_we    = 1'b1;
            v_waddr = clr_reg;
            v_wdata = '0;
        end
        if (state_reg == S_RDB)
        begin
            s_raddr = sp_m2[SAW-1:0];
        end
        if (state_reg == S_WB)
        begin
            unique case (op_reg)
                sme_pkg::OP_PUSH:
                begin
                    s_we    = 1'b1;
                    s_wdata = imm_reg;
                end
                sme_pkg::OP_PUSHV:
                begin
                    s_we    = 1'b1;
                    s_wdata = v_rdata;
                end
                sme_pkg::OP_POPV:
                begin
                    v_we = 1'b1;
                end
                default:
                begin
                    s_we    = binop;
                    s_waddr = sp_m2[SAW-1:0];
                end
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == VAW'(VAR_SLOTS - 1)) state_next = S_IDLE;
            S_IDLE:  if (in_valid && !in_stall) state_next = S_RDB;
            S_RDB:   state_next = S_RDA;
            S_RDA:   state_next = S_RDV;
            S_RDV:   state_next = S_EXEC;
            S_EXEC:  state_next = S_ITER;
            S_ITER:
            begin
                if ((op_reg == sme_pkg::OP_MUL && cnt_reg == 6'd2) ||
                    (op_reg == sme_pkg::OP_DIV && cnt_reg == 6'd32) ||
                    (op_reg != sme_pkg::OP_MUL && op_reg != sme_pkg::OP_DIV))
                begin
                    state_next = S_WB;
                end
            end
            S_WB:    state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            pc_reg      <= '0;
            sp_reg      <= '0;
            stop_reg    <= sme_pkg::ST_OK;
            clr_reg     <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (res_vld_reg && !out_stall)
            begin
                res_vld_reg <= 1'b0;
            end
            // Result and architectural update.
            if (state_reg == S_OUT)
            begin
                logic [2:0]     st;
                logic [PCW-1:0] nxt;
                logic [SPW-1:0] nsp;
                logic           ov;
                st  = sme_pkg::ST_OK;
                nxt = pc_inc;
                nsp = sp_reg;
                ov  = 1'b0;
                if (stop_reg != sme_pkg::ST_OK)
                begin
                    st  = stop_reg;
                    nxt = pc_reg;
                end
                else
                begin
                    case (op_reg)
                        sme_pkg::OP_HALT: st = sme_pkg::ST_HALT;
                        sme_pkg::OP_PUSH, sme_pkg::OP_PUSHV:
                        begin
                            if (full) st = sme_pkg::ST_OVER;
                            else nsp = sp_reg + 1'b1;
                        end
                        sme_pkg::OP_POP, sme_pkg::OP_POPV:
                        begin
                            if (!has1) st = sme_pkg::ST_UNDER;
                            else nsp = sp_m1;
                        end
                        sme_pkg::OP_OUT:
                        begin
                            if (!has1) st = sme_pkg::ST_UNDER;
                            else ov = 1'b1;
                        end
                        sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
                        sme_pkg::OP_DIV:
                        begin
                            if (!has2) st = sme_pkg::ST_UNDER;
                            else if (op_reg == sme_pkg::OP_DIV && b_reg == '0)
                                st = sme_pkg::ST_DIVZ;
                            else nsp = sp_m1;
                        end
                        sme_pkg::OP_JE, sme_pkg::OP_JL, sme_pkg::OP_JG:
                        begin
                            if (!has2) st = sme_pkg::ST_UNDER;
                            else
                            begin
                                nsp = sp_m2;
                                if (take) nxt = jmp_nxt;
                            end
                        end
                        sme_pkg::OP_JMP: nxt = jmp_nxt;
                        sme_pkg::OP_NOP: nxt = pc_inc;
                        default: st = sme_pkg::ST_UNKNOWN;
                    endcase
                    if (st != sme_pkg::ST_OK && st != sme_pkg::ST_UNKNOWN)
                    begin
                        stop_reg <= st;
                        nxt = pc_reg;
                    end
                    pc_reg <= nxt;
                    sp_reg <= nsp;
                end
                res_vld_reg <= 1'b1;
                r_pc_reg    <= 12'(nxt);
                r_st_reg    <= st;
                r_ov_reg    <= ov;
                r_val_reg   <= ov ? b_reg : 32'd0;
                r_sd_reg    <= 7'(nsp);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && !in_stall)
        begin
            op_reg   <= op;
            imm_reg  <= imm_value;
            tgt_reg  <= jump_target;
            slot_reg <= slot_map[var_index];
        end
        // The top entry arrives first, the entry below it in the cycle after.
        if (state_reg == S_RDB)
        begin
            b_reg <= s_rdata;
        end
        if (state_reg == S_RDA)
        begin
            a_reg <= s_rdata;
        end
        if (state_reg == S_EXEC)
        begin
            cnt_reg <= '0;
            rem_reg <= '0;
            neg_reg <= a_reg[31] ^ b_reg[31];
            unique case (op_reg)
                sme_pkg::OP_ADD: acc_reg <= a_reg + b_reg;
                sme_pkg::OP_SUB: acc_reg <= a_reg - b_reg;
                sme_pkg::OP_DIV: acc_reg <= ua;
                default:         acc_reg <= '0;
            endcase
        end
        if (state_reg == S_ITER)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (op_reg == sme_pkg::OP_MUL)
            begin
                if (cnt_reg == 6'd0)
                    acc_reg <= mres;
                else
                    acc_reg <= acc_reg + mres;
            end
            else if (op_reg == sme_pkg::OP_DIV)
            begin
                if (cnt_reg == 6'd32)
                begin
                    acc_reg <= neg_reg ? (32'd0 - acc_reg) : acc_reg;
                end
                else if (!trial[32])
                begin
                    rem_reg <= trial[31:0];
                    acc_reg <= {acc_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[30:0], acc_reg[31]};
                    acc_reg <= {acc_reg[30:0], 1'b0};
                end
            end
        end
    end

endmodule

// File: rtl/sme_ram.sv
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/stack_machine_executor_chk.sv
module stack_machine_executor_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid_o,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic        out_valid,
    input logic [6:0]  stack_depth
);

    // A result held under stall stays valid and keeps its status.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_o && out_stall |=> out_valid_o && $stable(status))
        else $error("result changed while stalled");

    // No item is taken while a result waits.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_o |-> in_stall)
        else $error("input accepted with a result pending");

    // An out value is only reported with an ok status and a non-empty stack.
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_o && out_valid |-> status == sme_pkg::ST_OK && stack_depth != 7'd0)
        else $error("out value with a fault or empty stack");

    // An accepted item does not produce its result in the next cycle.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid_o)
        else $error("result too early");

endmodule

bind stack_machine_executor stack_machine_executor_chk u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid_o(out_valid_o), .out_stall(out_stall), .status(status),
    .out_valid(out_valid), .stack_depth(stack_depth)
);
